// ----- rtl/hrp_pkg.sv -----
`timescale 1ns / 1ps
package hrp_pkg;

  localparam int unsigned OutDataW = 168;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;

  localparam logic [15:0] STATUS_OK_FULL    = 16'd200;
  localparam logic [15:0] STATUS_OK_PARTIAL = 16'd206;

  localparam logic [0:3][7:0]  PFX_HTTP   = "HTTP";
  localparam logic [0:14][7:0] PFX_LENGTH = "Content-Length:";
  localparam logic [0:13][7:0] PFX_RANGE  = "Content-Range:";

  typedef enum logic [1:0] {
    SEC_HEADER = 2'd0,
    SEC_CHUNK  = 2'd1,
    SEC_BODY   = 2'd2
  } section_e;

  typedef enum logic [2:0] {
    KIND_UNDECIDED = 3'd0,
    KIND_OTHER     = 3'd1,
    KIND_BLANK     = 3'd2,
    KIND_HTTP      = 3'd3,
    KIND_CONTENT   = 3'd4,
    KIND_LENGTH    = 3'd5,
    KIND_RANGE     = 3'd6
  } line_kind_e;

  typedef enum logic [1:0] {
    VERD_DELIVER    = 2'd0,
    VERD_NO_SIZE    = 2'd1,
    VERD_INCOMPLETE = 2'd2,
    VERD_UNFINISHED = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] status_code;
    logic        status_ok;
    logic [15:0] payload_size;
    logic [15:0] body_offset;
    logic [15:0] body_length;
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic [31:0] total_size;
  } result_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [3:0] prefix_len(line_kind_e k);
    logic [3:0] r;
    case (k)
      KIND_HTTP:    r = 4'd4;
      KIND_CONTENT: r = 4'd15;
      KIND_LENGTH:  r = 4'd15;
      KIND_RANGE:   r = 4'd14;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hrp_in_stage.sv -----
`timescale 1ns / 1ps
module hrp_in_stage import hrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       take_i,
  output logic       item_valid_o,
  output in_item_t   item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign s_axis_tready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= '{rx_byte: s_axis_tdata, end_of_buffer: s_axis_tlast};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/hrp_core.sv -----
`timescale 1ns / 1ps
module hrp_core import hrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  input  logic     out_free_i,
  output logic     take_o,
  output logic     res_valid_o,
  output result_t  res_o
);

  typedef struct packed {
    logic [15:0]      idx;
    logic [3:0]       col;
    line_kind_e       kind;
    logic [2:0]       phase;
    section_e         sec;
    logic [31:0]      acc;
    logic [15:0]      status;
    logic [15:0]      size;
    logic [2:0][31:0] rng;
    logic [15:0]      bstart;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    idx: '0, col: '0, kind: KIND_UNDECIDED, phase: '0, sec: SEC_HEADER,
    acc: '0, status: '0, size: '0, rng: '0, bstart: '0
  };

  parse_state_t st_q, st_d, nx;

  logic [7:0]  b;
  logic [15:0] next_pos;
  logic        digit;
  logic [35:0] mac;
  logic [31:0] acc_sat;
  logic [31:0] acc_wrap;
  logic [31:0] dval;
  logic [4:0]  hx;
  logic [1:0]  rk;
  logic [16:0] len_full;
  logic [15:0] len;
  verdict_e    verdict;

  assign take_o = item_valid_i && (!item_i.end_of_buffer || out_free_i);

  always_comb begin
    b        = item_i.rx_byte;
    next_pos = (st_q.idx != 16'hFFFF) ? st_q.idx + 16'd1 : 16'hFFFF;
    digit    = is_digit(b);
    dval     = {28'd0, b[3:0]};
    mac      = ({4'd0, st_q.acc} << 3) + ({4'd0, st_q.acc} << 1) + {32'd0, b[3:0]};
    acc_sat  = (mac[35:32] != 4'd0) ? 32'hFFFF_FFFF : mac[31:0];
    acc_wrap = mac[31:0];
    hx       = hex_nibble(b);
    rk       = st_q.phase[2:1];
    nx       = st_q;

    case (st_q.sec)
      SEC_HEADER: begin
        if (st_q.kind == KIND_UNDECIDED) begin
          if (b == CH_CR || b == CH_LF) nx.kind = KIND_BLANK;
          else if (b == CH_H)           nx.kind = KIND_HTTP;
          else if (b == CH_C)           nx.kind = KIND_CONTENT;
          else                          nx.kind = KIND_OTHER;
        end else if (st_q.col < prefix_len(st_q.kind)) begin
          case (st_q.kind)
            KIND_HTTP: begin
              if (b != PFX_HTTP[st_q.col[1:0]]) nx.kind = KIND_OTHER;
            end
            KIND_CONTENT: begin
              if (st_q.col < 4'd8) begin
                if (b != PFX_LENGTH[st_q.col]) nx.kind = KIND_OTHER;
              end else if (b == CH_L) begin
                nx.kind = KIND_LENGTH;
              end else if (b == CH_R) begin
                nx.kind = KIND_RANGE;
              end else begin
                nx.kind = KIND_OTHER;
              end
            end
            KIND_LENGTH: begin
              if (b != PFX_LENGTH[st_q.col]) nx.kind = KIND_OTHER;
            end
            KIND_RANGE: begin
              if (b != PFX_RANGE[st_q.col]) nx.kind = KIND_OTHER;
            end
            default: ;
          endcase
        end else begin
          case (st_q.kind)
            KIND_HTTP: begin
              if (st_q.phase == 3'd0) begin
                if (b == CH_SPACE) nx.phase = 3'd1;
              end else if (st_q.phase == 3'd1) begin
                if (digit) begin
                  nx.acc   = dval;
                  nx.phase = 3'd2;
                end
              end else if (st_q.phase == 3'd2) begin
                if (digit) nx.acc = acc_wrap;
                else       nx.phase = 3'd3;
              end
            end
            KIND_LENGTH: begin
              if (st_q.phase == 3'd0) begin
                if (digit) begin
                  nx.acc   = dval;
                  nx.phase = 3'd1;
                end
              end else if (st_q.phase == 3'd1) begin
                if (digit) nx.acc = acc_wrap;
                else       nx.phase = 3'd2;
              end
            end
            KIND_RANGE: begin
              // three numbers, each an idle even phase then a digit-run odd phase
              if (rk != 2'd3) begin
                if (st_q.phase[0]) begin
                  if (digit) begin
                    nx.acc = acc_sat;
                  end else begin
                    nx.rng[rk] = st_q.acc;
                    nx.acc     = '0;
                    nx.phase   = st_q.phase + 3'd1;
                  end
                end else if (digit) begin
                  nx.acc   = dval;
                  nx.phase = st_q.phase + 3'd1;
                end
              end
            end
            default: ;
          endcase
        end

        if (st_q.col != 4'd15) nx.col = st_q.col + 4'd1;

        if (b == CH_LF) begin
          case (nx.kind)
            KIND_HTTP: begin
              if (nx.acc[15:0] != 16'd0) nx.status = nx.acc[15:0];
            end
            KIND_LENGTH: begin
              if (nx.acc[15:0] != 16'd0) nx.size = nx.acc[15:0];
            end
            KIND_RANGE: begin
              // numbers missing at the line end read as zero
              for (int j = 0; j < 3; j++) begin
                if (2'(j) >= nx.phase[2:1]) nx.rng[j] = '0;
              end
            end
            KIND_BLANK: begin
              nx.sec    = (st_q.size != 16'd0) ? SEC_BODY : SEC_CHUNK;
              nx.bstart = next_pos;
            end
            default: ;
          endcase
          nx.col   = '0;
          nx.kind  = KIND_UNDECIDED;
          nx.phase = '0;
          nx.acc   = '0;
        end
      end

      SEC_CHUNK: begin
        if (st_q.phase == 3'd0) begin
          if (b == CH_CR || b == CH_LF) nx.phase = 3'd1;
          else if (hx[4])               nx.acc = {16'd0, st_q.acc[11:0], hx[3:0]};
        end
        if (b == CH_LF) begin
          if (nx.acc != 32'd0) nx.size = nx.acc[15:0];
          nx.sec    = SEC_BODY;
          nx.bstart = next_pos;
          nx.col    = '0;
          nx.kind   = KIND_UNDECIDED;
          nx.phase  = '0;
          nx.acc    = '0;
        end
      end

      default: ;
    endcase

    nx.idx = next_pos;

    len_full = {1'b0, st_q.idx} + 17'd1 - {1'b0, nx.bstart};
    if (nx.sec != SEC_BODY)  len = 16'd0;
    else if (len_full[16])   len = 16'hFFFF;
    else                     len = len_full[15:0];

    if (st_q.sec == SEC_CHUNK)       verdict = VERD_NO_SIZE;
    else if (nx.sec == SEC_HEADER)   verdict = VERD_UNFINISHED;
    else if (nx.sec == SEC_CHUNK)    verdict = VERD_NO_SIZE;
    else if (nx.size == 16'd0)       verdict = VERD_NO_SIZE;
    else if (nx.size > len)          verdict = VERD_INCOMPLETE;
    else                             verdict = VERD_DELIVER;

    res_o.verdict      = verdict;
    res_o.status_code  = nx.status;
    res_o.status_ok    = (nx.status == STATUS_OK_FULL) || (nx.status == STATUS_OK_PARTIAL);
    res_o.payload_size = nx.size;
    res_o.body_offset  = (nx.sec == SEC_BODY) ? nx.bstart : 16'd0;
    res_o.body_length  = len;
    res_o.range_first  = nx.rng[0];
    res_o.range_last   = nx.rng[1];
    res_o.total_size   = nx.rng[2];

    // every buffer starts from a clean parser
    st_d = item_i.end_of_buffer ? StateReset : nx;
  end

  assign res_valid_o = take_o && item_i.end_of_buffer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else if (take_o) begin
      st_q <= st_d;
    end
  end

  a_clean_after_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (st_q.idx == 16'd0 && st_q.sec == SEC_HEADER))
    else $error("parser state not cleared after final byte");

  a_undecided_at_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.sec == SEC_HEADER && st_q.kind == KIND_UNDECIDED) |->
      (st_q.col == 4'd0 && st_q.phase == 3'd0))
    else $error("line kind undecided past the first column");

  a_header_no_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.sec == SEC_HEADER) |-> (st_q.bstart == 16'd0))
    else $error("body start set while still in header");

  a_unfinished_no_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.verdict == VERD_UNFINISHED) |->
      (res_o.body_offset == 16'd0 && res_o.body_length == 16'd0))
    else $error("body located on an unfinished header");

endmodule

// ----- rtl/hrp_out_stage.sv -----
`timescale 1ns / 1ps
module hrp_out_stage import hrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  result_t             res_i,
  output logic                out_free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic    valid_q;
  result_t res_q;

  assign out_free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, res_q.total_size, res_q.range_last, res_q.range_first,
                          res_q.body_length, res_q.body_offset, res_q.payload_size,
                          res_q.status_ok, res_q.status_code, res_q.verdict};

endmodule

// ----- rtl/http_response_header_parser.sv -----
// http response header parser
// slave stream: one received buffer as bytes, tdata[7:0] is the byte and
// tlast marks the final byte of the buffer.
// master stream: one transaction per buffer, issued for the final byte only.
// it carries the verdict, status code, payload size, body offset and length
// and the three content-range numbers.
// throughput: one byte per cycle unless a final byte waits; each byte goes
// through an input register, one pass of the parser logic (the x10
// multiply-add on the number accumulator sets the longest path) and, for the
// final byte, the result register.
// when the receiver stalls, non-final bytes keep flowing; a final byte waits
// in the input register until the result register is free.
// reset clears the parser, both registers' valid flags and the byte count;
// every buffer starts from the reset state.
`timescale 1ns / 1ps
module http_response_header_parser import hrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] rx_byte
  input  logic                s_axis_tlast,  // end_of_buffer
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] verdict, [17:2] status_code, [18] status_ok, [34:19] payload_size,
  // [50:35] body_offset, [66:51] body_length, [98:67] range_first,
  // [130:99] range_last, [162:131] total_size, [167:163] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic     item_valid;
  in_item_t item;
  logic     take;
  logic     out_free;
  logic     res_valid;
  result_t  res;

  hrp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  hrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hrp_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_valid),
    .res_i        (res),
    .out_free_o   (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

// ----- bench/http_response_header_parser_test.sv -----
`timescale 1ns / 1ps
module http_response_header_parser_test;
  import hrp_pkg::*;

  class parse_scoreboard;
    result_t     pending_verdicts[$];
    int unsigned mismatches;

    logic [15:0] byte_pos;
    logic [3:0]  col;
    line_kind_e  kind;
    logic [2:0]  phase;
    section_e    section;
    logic [31:0] acc;
    logic [15:0] status;
    logic [15:0] size;
    logic [31:0] rng[3];
    logic [15:0] body_at;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void clear_line();
      col   = 4'd0;
      kind  = KIND_UNDECIDED;
      phase = 3'd0;
      acc   = 32'd0;
    endfunction

    function void restart();
      byte_pos = 16'd0;
      clear_line();
      section = SEC_HEADER;
      status  = 16'd0;
      size    = 16'd0;
      for (int k = 0; k < 3; k++) rng[k] = 32'd0;
      body_at = 16'd0;
    endfunction

    function bit dec_digit(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
    endfunction

    function bit hex_digit(logic [7:0] b, output logic [3:0] v);
      v = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
        v = 4'(b - 8'h30);
        return 1'b1;
      end
      if (b >= 8'h41 && b <= 8'h46) begin
        v = 4'(b - 8'h37);
        return 1'b1;
      end
      if (b >= 8'h61 && b <= 8'h66) begin
        v = 4'(b - 8'h57);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function int unsigned prefix_chars(line_kind_e k);
      case (k)
        KIND_HTTP:    return 4;
        KIND_CONTENT: return 15;
        KIND_LENGTH:  return 15;
        KIND_RANGE:   return 14;
        default:      return 0;
      endcase
    endfunction

    function void match_prefix(logic [7:0] b, int unsigned c);
      case (kind)
        KIND_HTTP: begin
          if (b != PFX_HTTP[c]) kind = KIND_OTHER;
        end
        KIND_CONTENT: begin
          // shared "Content-" stem, then L or R picks the header
          if (c < 8) begin
            if (b != PFX_LENGTH[c]) kind = KIND_OTHER;
          end else if (b == CH_L) begin
            kind = KIND_LENGTH;
          end else if (b == CH_R) begin
            kind = KIND_RANGE;
          end else begin
            kind = KIND_OTHER;
          end
        end
        KIND_LENGTH: begin
          if (b != PFX_LENGTH[c]) kind = KIND_OTHER;
        end
        KIND_RANGE: begin
          if (b != PFX_RANGE[c]) kind = KIND_OTHER;
        end
        default: ;
      endcase
    endfunction

    function void number_step(logic [7:0] b);
      logic [63:0] wide;
      int unsigned idx;
      if (kind == KIND_HTTP) begin
        case (phase)
          3'd0: if (b == CH_SPACE) phase = 3'd1;
          3'd1: begin
            if (dec_digit(b)) begin
              acc   = b - 32'h30;
              phase = 3'd2;
            end
          end
          3'd2: begin
            if (dec_digit(b)) acc = acc * 32'd10 + b - 32'h30;
            else phase = 3'd3;
          end
          default: ;
        endcase
      end else if (kind == KIND_LENGTH) begin
        case (phase)
          3'd0: begin
            if (dec_digit(b)) begin
              acc   = b - 32'h30;
              phase = 3'd1;
            end
          end
          3'd1: begin
            if (dec_digit(b)) acc = acc * 32'd10 + b - 32'h30;
            else phase = 3'd2;
          end
          default: ;
        endcase
      end else if (kind == KIND_RANGE) begin
        idx = phase >> 1;
        if (idx > 2) return;
        if (phase[0]) begin
          if (dec_digit(b)) begin
            wide = {32'd0, acc} * 64'd10 + b - 64'h30;
            acc  = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
          end else begin
            rng[idx] = acc;
            acc      = 32'd0;
            phase++;
          end
        end else if (dec_digit(b)) begin
          acc = b - 32'h30;
          phase++;
        end
      end
    endfunction

    function void header_byte(logic [7:0] b, logic [15:0] nxt);
      int unsigned c;
      c = col;
      if (kind == KIND_UNDECIDED) begin
        if (b == CH_CR || b == CH_LF) kind = KIND_BLANK;
        else if (b == CH_H) kind = KIND_HTTP;
        else if (b == CH_C) kind = KIND_CONTENT;
        else kind = KIND_OTHER;
      end else if (c < prefix_chars(kind)) begin
        match_prefix(b, c);
      end else begin
        number_step(b);
      end
      if (col < 4'd15) col++;
      if (b != CH_LF) return;
      case (kind)
        KIND_HTTP: begin
          if (acc[15:0] != 16'd0) status = acc[15:0];
        end
        KIND_LENGTH: begin
          if (acc[15:0] != 16'd0) size = acc[15:0];
        end
        KIND_RANGE: begin
          // numbers missing before the line end read as zero
          for (int k = phase >> 1; k < 3; k++) rng[k] = 32'd0;
        end
        KIND_BLANK: begin
          if (size != 16'd0) section = SEC_BODY;
          else section = SEC_CHUNK;
          body_at = nxt;
        end
        default: ;
      endcase
      clear_line();
    endfunction

    function void chunk_byte(logic [7:0] b, logic [15:0] nxt);
      logic [3:0] nib;
      if (phase == 3'd0) begin
        if (b == CH_CR || b == CH_LF) phase = 3'd1;
        else if (hex_digit(b, nib)) acc = ((acc << 4) | nib) & 32'hFFFF;
      end
      if (b != CH_LF) return;
      if (acc != 32'd0) size = acc[15:0];
      section = SEC_BODY;
      body_at = nxt;
      clear_line();
    endfunction

    function void take_byte(logic [7:0] b, logic is_final);
      section_e    was;
      logic [15:0] pos;
      logic [15:0] nxt;
      int unsigned len;
      logic [15:0] off;
      result_t     e;
      was = section;
      pos = byte_pos;
      nxt = (pos != 16'hFFFF) ? pos + 16'd1 : 16'hFFFF;
      len = 0;
      off = 16'd0;
      if (was == SEC_HEADER) header_byte(b, nxt);
      else if (was == SEC_CHUNK) chunk_byte(b, nxt);
      byte_pos = nxt;
      if (!is_final) return;

      if (section == SEC_BODY) begin
        off = body_at;
        len = int'(pos) + 1 - int'(body_at);
        if (len > 65535) len = 65535;
      end
      if (was == SEC_CHUNK) e.verdict = VERD_NO_SIZE;
      else if (section == SEC_HEADER) e.verdict = VERD_UNFINISHED;
      else if (section == SEC_CHUNK) e.verdict = VERD_NO_SIZE;
      else if (size == 16'd0) e.verdict = VERD_NO_SIZE;
      else if (int'(size) > len) e.verdict = VERD_INCOMPLETE;
      else e.verdict = VERD_DELIVER;
      e.status_code  = status;
      e.status_ok    = (status == STATUS_OK_FULL) || (status == STATUS_OK_PARTIAL);
      e.payload_size = size;
      e.body_offset  = off;
      e.body_length  = len[15:0];
      e.range_first  = rng[0];
      e.range_last   = rng[1];
      e.total_size   = rng[2];
      pending_verdicts.push_back(e);
      restart();
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_verdict(logic [OutDataW-1:0] d);
      result_t e;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transaction with no final byte outstanding");
        return;
      end
      e = pending_verdicts.pop_front();
      compare_field("verdict",      d[1:0],     e.verdict);
      compare_field("status_code",  d[17:2],    e.status_code);
      compare_field("status_ok",    d[18],      e.status_ok);
      compare_field("payload_size", d[34:19],   e.payload_size);
      compare_field("body_offset",  d[50:35],   e.body_offset);
      compare_field("body_length",  d[66:51],   e.body_length);
      compare_field("range_first",  d[98:67],   e.range_first);
      compare_field("range_last",   d[130:99],  e.range_last);
      compare_field("total_size",   d[162:131], e.total_size);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  parse_scoreboard sb;
  logic [7:0]      frame_bytes[$];
  int unsigned     send_idle;
  int unsigned     recv_idle;
  int unsigned     bytes_sent;
  int unsigned     frames_sent;

  http_response_header_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // outputs only move at the rising edge, so the falling edge sees them settled
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic void put_eol();
    if ($urandom_range(0, 3) != 0) frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
  endfunction

  function automatic void put_digits(int unsigned n);
    repeat (n) frame_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
  endfunction

  function automatic void put_noise(int unsigned n, bit allow_lf);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (!allow_lf && b == CH_LF);
      frame_bytes.push_back(b);
    end
  endfunction

  // mostly hex, now and then a character the chunk line should skip
  function automatic void put_chunk_size();
    string chars;
    chars = "0123456789abcdefABCDEFgx- ";
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 1) begin
      frame_bytes.push_back(chars[$urandom_range(0, chars.len() - 1)]);
    end
  endfunction

  function automatic void build_random_frame();
    int unsigned pick;
    int unsigned clen;
    int unsigned body_len;
    bit          has_len;
    frame_bytes.delete();
    has_len = 1'b0;
    clen    = 0;

    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if ($urandom_range(0, 9) == 0) put_str("HTTP/1.0  ");
      else put_str("HTTP/1.1 ");
      case ($urandom_range(0, 5))
        0:       put_str("200");
        1:       put_str("206");
        2:       put_str("0");
        3:       put_digits($urandom_range(4, 9));
        default: put_digits($urandom_range(1, 3));
      endcase
      if ($urandom_range(0, 1)) put_str(" OK");
      put_eol();
    end else if (pick < 85) begin
      put_str("HTTX/1.1 200");
      put_eol();
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) put_str("HTTP/1.1");
      else put_str("HTTP/1.1 none");
      put_eol();
    end

    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 6))
        0, 1: begin
          put_str("Content-Length: ");
          if ($urandom_range(0, 3) != 0) begin
            clen = $urandom_range(0, 48);
            put_str($sformatf("%0d", clen));
          end else begin
            clen = 0;
            put_digits($urandom_range(1, 7));
          end
          has_len = 1'b1;
        end
        2: begin
          put_str("Content-Range: bytes ");
          put_digits($urandom_range(1, $urandom_range(0, 1) ? 4 : 12));
          if ($urandom_range(0, 4) != 0) begin
            frame_bytes.push_back("-");
            put_digits($urandom_range(1, $urandom_range(0, 1) ? 4 : 12));
            if ($urandom_range(0, 4) != 0) begin
              frame_bytes.push_back("/");
              if ($urandom_range(0, 5) == 0) put_str("*");
              else put_digits($urandom_range(1, $urandom_range(0, 1) ? 4 : 12));
            end
          end
        end
        3: begin
          case ($urandom_range(0, 5))
            0: put_str("Content-Type: text/html");
            1: put_str("Content-Lengt: 12");
            2: put_str("Content-Rangx: 1-2/3");
            3: put_str("Content-Length:");
            4: put_str("Content-Range: none");
            default: put_str("Connection: close");
          endcase
        end
        default: begin
          put_noise(1, 1'b0);
          put_noise($urandom_range(0, 24), 1'b0);
        end
      endcase
      put_eol();
    end

    if ($urandom_range(0, 9) != 0) put_eol();
    if (!has_len || $urandom_range(0, 4) == 0) begin
      put_chunk_size();
      put_eol();
    end

    if (has_len && clen != 0 && $urandom_range(0, 1)) body_len = clen + $urandom_range(0, 4);
    else body_len = $urandom_range(0, 40);
    if (body_len > 3 && $urandom_range(0, 3) == 0) body_len -= 3;
    put_noise(body_len, 1'b1);

    if (frame_bytes.size() == 0) put_noise(1, 1'b1);
    if (frame_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
      frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 1)];
    end
  endfunction

  task automatic drive_byte(logic [7:0] b, logic is_final);
    if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_final;
    do @(negedge clk_i); while (!s_axis_tready);
    sb.take_byte(b, is_final);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  task automatic send_text(string s);
    frame_bytes.delete();
    put_str(s);
    send_frame();
  endtask

  initial begin
    #5_000_000;
    $display("FAIL http_response_header_parser");
    $finish;
  end

  initial begin
    int unsigned start_bytes;
    int unsigned start_frames;
    sb            = new();
    bytes_sent    = 0;
    frames_sent   = 0;
    send_idle     = 23;
    recv_idle     = 85;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tlast  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // header cut short by the final byte
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    // blank line completed by the final byte, no size known
    send_text("\n");
    // chunk line still open at the final byte, closed before it, or closed by it
    send_text("\nA");
    send_text("\n1\nZ");
    send_text("\nf\n");
    // size, or just a status, known when the blank line closes the buffer
    frame_bytes.delete();
    put_str("Content-Length: 3");
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
    send_frame();
    send_text("HTTP 206\n\n");

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 23;
          recv_idle = 85;
        end
        1: begin
          send_idle = 85;
          recv_idle = 23;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      start_bytes  = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < 580 || frames_sent - start_frames < 4) begin
        build_random_frame();
        send_frame();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS http_response_header_parser");
    end else begin
      $display("FAIL http_response_header_parser");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hrp_pkg.sv
rtl/hrp_in_stage.sv
rtl/hrp_core.sv
rtl/hrp_out_stage.sv
rtl/http_response_header_parser.sv
bench/http_response_header_parser_test.sv
